@@ src/rto_pkg.sv @@
// Shared types and constants for the retransmission-timeout estimator.
// Holds command and status codes, field widths and controller/datapath structs.
// No dependencies.
package rto_pkg;

   localparam int ID_W    = 16;
   localparam int TS_W    = 64;
   localparam int RTO_W   = 32;
   localparam int ENTRY_W = 1 + ID_W + TS_W;

   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_FORGET = 2'd1;
   localparam logic [1:0] CMD_ACK    = 2'd2;
   localparam logic [1:0] CMD_QUERY  = 2'd3;

   localparam logic [1:0] ST_NONE    = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_STALE   = 2'd2;
   localparam logic [1:0] ST_SAMPLE  = 2'd3;

   localparam logic [RTO_W-1:0] INIT_DEV = 32'd15;
   localparam logic [RTO_W-1:0] INIT_RTO = 32'd1000;
   localparam logic [RTO_W-1:0] RTO_MAX  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic clear;
      logic capture;
      logic lookup;
      logic err;
      logic adj;
      logic dev;
      logic peak;
      logic rto;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic sample;
   } dp_status_type;

endpackage

@@ src/rto_estimator.sv @@
// A word accepted at start&&!busy runs the lookup and err states, then its
// registered result strobe follows; an ack that yields an RTT sample first also
// runs adj, dev, peak and rto (one step per filter update). Busy holds off a new
// word until the strobe; the next word may be taken in the cycle of the strobe.
// The receiver cannot stall. Reset: synchronous; busy stays high for a clearing
// pass over every slot of the send-time store, then the block goes idle.
module rto_estimator
   import rto_pkg::*;
#(
   parameter int SLOT_INDEX_BITS = 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_cmd,
   input  logic [ID_W-1:0]  req_packet_id,
   input  logic [TS_W-1:0]  req_timestamp,
   output logic             rsp_strobe,
   output logic [RTO_W-1:0] rsp_rto_value,
   output logic [1:0]       rsp_ack_status
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rto_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   rto_dp #(
      .SLOT_INDEX_BITS (SLOT_INDEX_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_cmd        (req_cmd),
      .req_packet_id  (req_packet_id),
      .req_timestamp  (req_timestamp),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_rto_value  (rsp_rto_value),
      .rsp_ack_status (rsp_ack_status)
   );

endmodule

@@ src/rto_ctrl.sv @@
// Controller state machine of the estimator: clearing pass, lookup, update steps.
// Depends on rto_pkg; drives rto_dp through ctrl_cmd_type.
module rto_ctrl
   import rto_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output logic          busy,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOOKUP = 3'd2;
   localparam logic [2:0] S_ERR    = 3'd3;
   localparam logic [2:0] S_ADJ    = 3'd4;
   localparam logic [2:0] S_DEV    = 3'd5;
   localparam logic [2:0] S_PEAK   = 3'd6;
   localparam logic [2:0] S_RTO    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_ERR;
         end
         S_ERR: begin
            cmd.err = 1'b1;
            if (status.sample) begin
               state_in = S_ADJ;
            end else begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_ADJ: begin
            cmd.adj  = 1'b1;
            state_in = S_DEV;
         end
         S_DEV: begin
            cmd.dev  = 1'b1;
            state_in = S_PEAK;
         end
         S_PEAK: begin
            cmd.peak = 1'b1;
            state_in = S_RTO;
         end
         S_RTO: begin
            cmd.rto     = 1'b1;
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ src/rto_dp.sv @@
// Datapath of the estimator: send-time store, lookup, RTT filter and timeout.
// Depends on rto_pkg; steered by rto_ctrl through ctrl_cmd_type.
module rto_dp
   import rto_pkg::*;
#(
   parameter int SLOT_INDEX_BITS = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   input  logic [1:0]          req_cmd,
   input  logic [ID_W-1:0]     req_packet_id,
   input  logic [TS_W-1:0]     req_timestamp,
   output dp_status_type       status,
   output logic                rsp_strobe,
   output logic [RTO_W-1:0]    rsp_rto_value,
   output logic [1:0]          rsp_ack_status
);

   localparam int SLOTS = 1 << SLOT_INDEX_BITS;

   logic [ENTRY_W-1:0]         mem [SLOTS];
   logic [ENTRY_W-1:0]         rd_ff;
   logic [SLOT_INDEX_BITS-1:0] clr_ff;
   logic [1:0]                 cmd_ff;
   logic [ID_W-1:0]            id_ff;
   logic [TS_W-1:0]            ts_ff;
   logic [1:0]                 status_ff;
   logic [1:0]                 status_in;
   logic [RTO_W-1:0]           m_ff;
   logic [RTO_W-1:0]           err_ff;
   logic                       first_ff;
   logic [RTO_W-1:0]           delta_ff;
   logic [RTO_W-1:0]           srtt_ff;
   logic [RTO_W-1:0]           mdev_ff;
   logic [RTO_W-1:0]           peak_ff;
   logic [RTO_W-1:0]           rto_ff;
   logic                       strobe_ff;

   logic                       we;
   logic [SLOT_INDEX_BITS-1:0] waddr;
   logic [ENTRY_W-1:0]         wdata;
   logic                       rd_valid;
   logic [ID_W-1:0]            rd_tag;
   logic [TS_W-1:0]            rd_time;
   logic                       hit;
   logic [RTO_W-1:0]           mag;
   logic [RTO_W+1:0]           rto_sum;

   assign rd_valid = rd_ff[ENTRY_W-1];
   assign rd_tag   = rd_ff[ENTRY_W-2 -: ID_W];
   assign rd_time  = rd_ff[TS_W-1:0];
   assign hit      = rd_valid && (rd_tag == id_ff);
   assign mag      = err_ff[RTO_W-1] ? (~err_ff + 32'd1) : err_ff;
   assign rto_sum  = {2'b00, srtt_ff} + {peak_ff, 2'b00};

   always_comb begin
      we    = 1'b0;
      waddr = id_ff[SLOT_INDEX_BITS-1:0];
      wdata = {1'b1, id_ff, ts_ff};
      if (cmd.clear) begin
         we    = 1'b1;
         waddr = clr_ff;
         wdata = '0;
      end else if (cmd.lookup) begin
         case (cmd_ff)
            CMD_RECORD: begin
               we = 1'b1;
            end
            CMD_FORGET: begin
               we    = hit;
               wdata = {1'b0, id_ff, ts_ff};
            end
            default: begin
               we = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (cmd_ff)
         CMD_ACK: begin
            if (!hit) begin
               status_in = ST_UNKNOWN;
            end else if (ts_ff <= rd_time) begin
               status_in = ST_STALE;
            end else begin
               status_in = ST_SAMPLE;
            end
         end
         default: begin
            status_in = ST_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.capture) begin
         rd_ff <= mem[req_packet_id[SLOT_INDEX_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         id_ff  <= req_packet_id;
         ts_ff  <= req_timestamp;
      end
      if (cmd.lookup) begin
         status_ff <= status_in;
         m_ff      <= ts_ff[RTO_W-1:0] - rd_time[RTO_W-1:0];
      end
      if (cmd.err) begin
         err_ff   <= m_ff - srtt_ff;
         first_ff <= (srtt_ff == '0);
      end
      if (cmd.adj) begin
         delta_ff <= mag - mdev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         srtt_ff   <= '0;
         mdev_ff   <= INIT_DEV;
         peak_ff   <= INIT_DEV;
         rto_ff    <= INIT_RTO;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.respond;
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.adj) begin
            if (first_ff) begin
               srtt_ff <= m_ff;
               mdev_ff <= m_ff >> 1;
            end else begin
               srtt_ff <= srtt_ff + RTO_W'($signed(err_ff) >>> 3);
            end
         end
         if (cmd.dev && !first_ff) begin
            mdev_ff <= mdev_ff + RTO_W'($signed(delta_ff) >>> 2);
         end
         if (cmd.peak && (mdev_ff > peak_ff)) begin
            peak_ff <= mdev_ff;
         end
         if (cmd.rto) begin
            rto_ff <= (rto_sum[RTO_W+1:RTO_W] != 2'b00) ? RTO_MAX : rto_sum[RTO_W-1:0];
         end
      end
   end

   assign status.clear_last = &clr_ff;
   assign status.sample     = (status_ff == ST_SAMPLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_rto_value     = rto_ff;
   assign rsp_ack_status    = status_ff;

endmodule

@@ src/rto_checker.sv @@
// Port-level checks for rto_estimator, attached by the bind at the end.
// Depends on rto_pkg for field widths and codes.
module rto_checker
   import rto_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [1:0]       req_cmd,
   input logic             rsp_strobe,
   input logic [RTO_W-1:0] rsp_rto_value,
   input logic [1:0]       rsp_ack_status
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after an accepted word");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_non_ack: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd != CMD_ACK) |-> ##3 (rsp_strobe && rsp_ack_status == ST_NONE))
      else $error("non-ack word did not return status none after 3 cycles");

   a_rto_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_ack_status != ST_SAMPLE) |-> $stable(rsp_rto_value))
      else $error("timeout changed without an RTT sample");

endmodule

bind rto_estimator rto_checker u_chk (.*);
